@@ hw/rtl/scps_pkg.sv @@
package scps_pkg;

   localparam int RING_DEPTH_DEFAULT = 16384;

   localparam int SAMPLE_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 19;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEEDBACK = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WET      = 3'd4;

   localparam logic [18:0] SPEED_RESET    = 19'd65536;
   localparam logic [13:0] WIDTH_RESET    = 14'd168;
   localparam logic [16:0] FEEDBACK_RESET = 17'd0;
   localparam logic [16:0] TRIM_RESET     = 17'd65536;
   localparam logic [16:0] WET_RESET      = 17'd65536;

   localparam logic [16:0] ONE_Q16   = 17'd65536;
   localparam logic [31:0] UNITY_Q24 = 32'd16777216;

   localparam int MAC_A_W = 35;
   localparam int MAC_B_W = 19;
   localparam int MAC_P_W = MAC_A_W + MAC_B_W;
   localparam int MAC_ACC_W = 56;

   localparam int DIV_NUM_W = 58;
   localparam int DIV_DEN_W = 32;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_left;
      logic signed [SAMPLE_W-1:0] in_right;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
   } rsp_type;

   typedef struct packed {
      logic                      issue;
      logic                      clear;
      logic signed [MAC_A_W-1:0] a;
      logic signed [MAC_B_W-1:0] b;
   } mac_op_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
      logic [DIV_DEN_W-1:0] rem;
   } div_rsp_type;

endpackage

@@ hw/rtl/scps_mac.sv @@
module scps_mac
   import scps_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  mac_op_type                  op,
   output logic signed [MAC_ACC_W-1:0] acc
);

   logic signed [MAC_P_W-1:0]   prod_ff;
   logic                        vld_ff;
   logic                        clr_ff;
   logic signed [MAC_ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op.a * op.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         clr_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         vld_ff <= op.issue;
         clr_ff <= op.clear;
         if (vld_ff) begin
            if (clr_ff) begin
               acc_ff <= MAC_ACC_W'(prod_ff);
            end else begin
               acc_ff <= acc_ff + MAC_ACC_W'(prod_ff);
            end
         end
      end
   end

   assign acc = acc_ff;

endmodule

@@ hw/rtl/scps_div.sv @@
module scps_div
   import scps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // One quotient bit per cycle, restoring form.
   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.num;
         rem_ff <= '0;
         den_ff <= req.den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
         if (fits) begin
            rem_ff <= DIV_DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_ff <= trial[DIV_DEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

@@ hw/rtl/scps_ring.sv @@
module scps_ring
   import scps_pkg::*;
#(
   parameter int DEPTH = RING_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [63:0]   wdata,
   output logic [63:0]   rdata,
   output logic          busy
);

   logic [63:0]   mem [DEPTH];
   logic [63:0]   rdata_ff;
   logic          clr_ff;
   logic [AW-1:0] clr_idx_ff;

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   // Zeroing sweep after reset, one entry per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         if (clr_idx_ff == AW'(DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end else begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   assign rdata = rdata_ff;
   assign busy  = clr_ff;

endmodule

@@ hw/rtl/splice_crossfade_pitch_shifter.sv @@
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_data (in_left, in_right)
// rsp_      out        rsp_valid/rsp_stall  rsp_data (out_left, out_right)
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// A stereo pair is sequenced from the accepted request to its result through one
// shared multiply-accumulate unit, whose product and accumulator are registered,
// and the next request is taken only after the sequencer returns to idle.
// A feedback division or a deep pointer wrap adds a pass through the bit-serial
// divider.
// After reset the ring is zeroed entry by entry, during which req_stall
// is high. The result register lets the next request be taken while rsp_stall
// holds the previous result; a pair that finishes while that result is still
// held waits in its last state.
module splice_crossfade_pitch_shifter
   import scps_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int PW  = AW + 16;
   localparam int PSW = AW + 17;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_FB_MUL   = 5'd1;
   localparam logic [4:0] ST_FB_ACC   = 5'd2;
   localparam logic [4:0] ST_FB_DIV   = 5'd3;
   localparam logic [4:0] ST_FB_SAT   = 5'd4;
   localparam logic [4:0] ST_WRITE    = 5'd5;
   localparam logic [4:0] ST_WRAP_WI  = 5'd6;
   localparam logic [4:0] ST_WI_DIV   = 5'd7;
   localparam logic [4:0] ST_WRAP_POS = 5'd8;
   localparam logic [4:0] ST_POS_DIV  = 5'd9;
   localparam logic [4:0] ST_RD0      = 5'd10;
   localparam logic [4:0] ST_RD1      = 5'd11;
   localparam logic [4:0] ST_RD2      = 5'd12;
   localparam logic [4:0] ST_RD3      = 5'd13;
   localparam logic [4:0] ST_IP_MUL0  = 5'd14;
   localparam logic [4:0] ST_IP_MUL1  = 5'd15;
   localparam logic [4:0] ST_IP_RND   = 5'd16;
   localparam logic [4:0] ST_FADE     = 5'd17;
   localparam logic [4:0] ST_MIX_MUL0 = 5'd18;
   localparam logic [4:0] ST_MIX_MUL1 = 5'd19;
   localparam logic [4:0] ST_MIX_RND  = 5'd20;
   localparam logic [4:0] ST_TRIM_MUL = 5'd21;
   localparam logic [4:0] ST_TRIM_RND = 5'd22;
   localparam logic [4:0] ST_WET_MUL0 = 5'd23;
   localparam logic [4:0] ST_WET_MUL1 = 5'd24;
   localparam logic [4:0] ST_OUT_RND  = 5'd25;
   localparam logic [4:0] ST_DONE     = 5'd26;
   localparam logic [4:0] ST_WAIT     = 5'd27;

   function automatic logic signed [39:0] rnd16(input logic signed [MAC_ACC_W-1:0] v);
      logic signed [MAC_ACC_W:0] b;
      b = (MAC_ACC_W+1)'(v) + (MAC_ACC_W+1)'(32768);
      return 40'(b >>> 16);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      if (v > 40'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   function automatic logic signed [31:0] sample(input logic [63:0] row, input logic ch);
      return ch ? $signed(row[31:0]) : $signed(row[63:32]);
   endfunction

   // Configuration.
   logic [18:0] speed_ff;
   logic [13:0] width_ff;
   logic [16:0] feedback_ff;
   logic [16:0] trim_ff;
   logic [16:0] wet_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff    <= SPEED_RESET;
         width_ff    <= WIDTH_RESET;
         feedback_ff <= FEEDBACK_RESET;
         trim_ff     <= TRIM_RESET;
         wet_ff      <= WET_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED:    speed_ff    <= csr_data;
            CSR_WIDTH:    width_ff    <= csr_data[13:0];
            CSR_FEEDBACK: feedback_ff <= csr_data[16:0];
            CSR_TRIM:     trim_ff     <= csr_data[16:0];
            CSR_WET:      wet_ff      <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // Effective wrap point.
   logic [AW-1:0] w_eff;
   logic [PW-1:0] span;

   always_comb begin
      if (width_ff == 14'd0) begin
         w_eff = AW'(1);
      end else if ({3'b0, width_ff} > 17'(RING_DEPTH - 1)) begin
         w_eff = AW'(RING_DEPTH - 1);
      end else begin
         w_eff = AW'(width_ff);
      end
   end

   assign span = {w_eff, 16'b0};

   // Sequencer and working registers.
   logic [4:0]               state_ff;
   logic [4:0]               ret_ff;
   logic                     ch_ff;
   logic signed [24:0]       dry_ff [2];
   logic signed [31:0]       feed_ff [2];
   logic signed [31:0]       last_ff [2];
   logic [16:0]              fade_ff [2];
   logic signed [23:0]       out_ff [2];
   logic signed [39:0]       t_ff;
   logic                     neg_ff;
   logic signed [39:0]       ip_ff;
   logic [AW-1:0]            wr_idx_ff;
   logic [PW-1:0]            rpos_ff;
   logic                     pending_ff;
   logic [AW:0]              wi_ff;
   logic [PSW-1:0]           pos_ff;
   logic [63:0]              r0_ff;
   logic [63:0]              r1_ff;
   logic [63:0]              old_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   mac_op_type               mac_op;
   logic signed [MAC_ACC_W-1:0] acc;
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   logic                     ring_we;
   logic [AW-1:0]            ring_addr;
   logic [63:0]              ring_rdata;
   logic                     ring_busy;

   scps_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (acc)
   );

   scps_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   scps_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock (clock),
      .reset (reset),
      .we    (ring_we),
      .addr  (ring_addr),
      .wdata ({feed_ff[0], feed_ff[1]}),
      .rdata (ring_rdata),
      .busy  (ring_busy)
   );

   // Combinational helpers.
   logic signed [39:0] acc_rnd;
   logic signed [39:0] fb_sum;
   logic [39:0]        fb_abs;
   logic [31:0]        last_mag;
   logic [AW:0]        wi_next;
   logic [PSW-1:0]     pos_next;
   logic [AW-1:0]      count;
   logic [AW-1:0]      i1;
   logic [15:0]        frac;
   logic signed [31:0] old_smp;
   logic signed [40:0] diff_s;
   logic [40:0]        diff;
   logic signed [40:0] out_half;
   logic signed [39:0] out_full;

   assign acc_rnd  = rnd16(acc);
   assign fb_sum   = 40'(dry_ff[ch_ff]) + acc_rnd;
   assign fb_abs   = fb_sum[39] ? 40'(-fb_sum) : 40'(fb_sum);
   assign last_mag = last_ff[ch_ff][31] ? 32'(-33'(last_ff[ch_ff]))
                                        : 32'(last_ff[ch_ff]);
   assign wi_next  = (AW+1)'(wr_idx_ff) + 1'b1;
   assign pos_next = PSW'(rpos_ff) + PSW'(speed_ff);
   assign count    = pos_ff[PW-1:16];
   assign i1       = (count == w_eff) ? '0 : count + 1'b1;
   assign frac     = pos_ff[15:0];
   assign old_smp  = sample(old_ff, ch_ff);
   assign diff_s   = 41'(ip_ff) - 41'(old_smp);
   assign diff     = diff_s[40] ? 41'(-diff_s) : 41'(diff_s);
   assign out_full = acc_rnd;
   assign out_half = (41'(out_full) + 41'sd1) >>> 1;

   always_comb begin
      mac_op   = '0;
      div_req  = '0;
      ring_we  = 1'b0;
      ring_addr = wr_idx_ff;
      case (state_ff)
         ST_FB_MUL: begin
            mac_op = '{issue: 1'b1, clear: 1'b1, a: MAC_A_W'(last_ff[ch_ff]),
                       b: MAC_B_W'($signed({2'b0, feedback_ff}))};
         end
         ST_FB_ACC: begin
            div_req.start = last_mag > UNITY_Q24;
            div_req.num   = {fb_abs[33:0], 24'b0};
            div_req.den   = last_mag;
         end
         ST_WRITE: begin
            ring_we = 1'b1;
         end
         ST_WRAP_WI: begin
            div_req.start = (wi_ff > (AW+1)'(w_eff))
                            && ((wi_ff - (AW+1)'(w_eff)) > (AW+1)'(w_eff));
            div_req.num   = DIV_NUM_W'(wr_idx_ff);
            div_req.den   = DIV_DEN_W'(w_eff);
         end
         ST_WRAP_POS: begin
            div_req.start = (pos_ff > PSW'(span))
                            && ((pos_ff - PSW'(span)) > PSW'(span));
            div_req.num   = DIV_NUM_W'(pos_ff - 1'b1);
            div_req.den   = DIV_DEN_W'(span);
         end
         ST_RD0: ring_addr = count;
         ST_RD1: ring_addr = i1;
         ST_RD2: ring_addr = wi_ff[AW-1:0];
         ST_IP_MUL0: begin
            mac_op = '{issue: 1'b1, clear: 1'b1, a: MAC_A_W'(sample(r0_ff, ch_ff)),
                       b: MAC_B_W'($signed({2'b0, ONE_Q16}) - $signed({3'b0, frac}))};
         end
         ST_IP_MUL1: begin
            mac_op = '{issue: 1'b1, clear: 1'b0, a: MAC_A_W'(sample(r1_ff, ch_ff)),
                       b: MAC_B_W'($signed({3'b0, frac}))};
         end
         ST_MIX_MUL0: begin
            mac_op = '{issue: 1'b1, clear: 1'b1, a: MAC_A_W'(old_smp),
                       b: MAC_B_W'($signed({2'b0, fade_ff[ch_ff]}))};
         end
         ST_MIX_MUL1: begin
            mac_op = '{issue: 1'b1, clear: 1'b0, a: MAC_A_W'(ip_ff),
                       b: MAC_B_W'($signed({2'b0, ONE_Q16})
                                   - $signed({2'b0, fade_ff[ch_ff]}))};
         end
         ST_TRIM_MUL: begin
            mac_op = '{issue: 1'b1, clear: 1'b1, a: MAC_A_W'(last_ff[ch_ff]),
                       b: MAC_B_W'($signed({2'b0, trim_ff}))};
         end
         ST_WET_MUL0: begin
            mac_op = '{issue: 1'b1, clear: 1'b1, a: MAC_A_W'(t_ff),
                       b: MAC_B_W'($signed({2'b0, wet_ff}))};
         end
         ST_WET_MUL1: begin
            mac_op = '{issue: 1'b1, clear: 1'b0, a: MAC_A_W'(dry_ff[ch_ff]),
                       b: MAC_B_W'($signed({2'b0, ONE_Q16}) - $signed({2'b0, wet_ff}))};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         ch_ff        <= 1'b0;
         wr_idx_ff    <= '0;
         rpos_ff      <= '0;
         pending_ff   <= 1'b0;
         fade_ff[0]   <= '0;
         fade_ff[1]   <= '0;
         last_ff[0]   <= '0;
         last_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The last state reloads the result register itself.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !ring_busy) begin
                  dry_ff[0] <= {req_data.in_left, 1'b0};
                  dry_ff[1] <= {req_data.in_right, 1'b0};
                  ch_ff     <= 1'b0;
                  state_ff  <= ST_FB_MUL;
               end
            end
            ST_FB_MUL: begin
               ret_ff   <= ST_FB_ACC;
               state_ff <= ST_WAIT;
            end
            ST_FB_ACC: begin
               t_ff   <= fb_sum;
               neg_ff <= fb_sum[39];
               // Previous output above unity: scale the sum down by its magnitude.
               state_ff <= (last_mag > UNITY_Q24) ? ST_FB_DIV : ST_FB_SAT;
            end
            ST_FB_DIV: begin
               if (div_rsp.done) begin
                  t_ff <= neg_ff ? -$signed(40'(div_rsp.quo[38:0]))
                                 : $signed(40'(div_rsp.quo[38:0]));
                  state_ff <= ST_FB_SAT;
               end
            end
            ST_FB_SAT: begin
               feed_ff[ch_ff] <= sat32(t_ff);
               ch_ff          <= ~ch_ff;
               state_ff       <= ch_ff ? ST_WRITE : ST_FB_MUL;
            end
            ST_WRITE: begin
               wi_ff  <= wi_next;
               pos_ff <= pos_next;
               if (pending_ff && (pos_next > {wi_next, 16'b0})) begin
                  fade_ff[0] <= ONE_Q16;
                  fade_ff[1] <= ONE_Q16;
                  pending_ff <= 1'b0;
               end
               state_ff <= ST_WRAP_WI;
            end
            ST_WRAP_WI: begin
               state_ff <= ST_WRAP_POS;
               if (wi_ff > (AW+1)'(w_eff)) begin
                  if ((wi_ff - (AW+1)'(w_eff)) > (AW+1)'(w_eff)) begin
                     state_ff <= ST_WI_DIV;
                  end else begin
                     wi_ff <= wi_ff - (AW+1)'(w_eff);
                  end
               end
            end
            ST_WI_DIV: begin
               if (div_rsp.done) begin
                  wi_ff    <= (AW+1)'(div_rsp.rem) + 1'b1;
                  state_ff <= ST_WRAP_POS;
               end
            end
            ST_WRAP_POS: begin
               state_ff <= ST_RD0;
               if (pos_ff > PSW'(span)) begin
                  pending_ff <= 1'b1;
                  if ((pos_ff - PSW'(span)) > PSW'(span)) begin
                     state_ff <= ST_POS_DIV;
                  end else begin
                     pos_ff <= pos_ff - PSW'(span);
                  end
               end
            end
            ST_POS_DIV: begin
               if (div_rsp.done) begin
                  pos_ff   <= PSW'(div_rsp.rem) + 1'b1;
                  state_ff <= ST_RD0;
               end
            end
            ST_RD0: begin
               wr_idx_ff <= wi_ff[AW-1:0];
               rpos_ff   <= pos_ff[PW-1:0];
               state_ff  <= ST_RD1;
            end
            ST_RD1: begin
               r0_ff    <= ring_rdata;
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               r1_ff    <= ring_rdata;
               state_ff <= ST_RD3;
            end
            ST_RD3: begin
               old_ff   <= ring_rdata;
               ch_ff    <= 1'b0;
               state_ff <= ST_IP_MUL0;
            end
            ST_IP_MUL0: state_ff <= ST_IP_MUL1;
            ST_IP_MUL1: begin
               ret_ff   <= ST_IP_RND;
               state_ff <= ST_WAIT;
            end
            ST_IP_RND: begin
               ip_ff    <= acc_rnd;
               state_ff <= ST_FADE;
            end
            ST_FADE: begin
               if (42'({fade_ff[ch_ff], 8'b0}) > {diff, 1'b0}) begin
                  fade_ff[ch_ff] <= (fade_ff[ch_ff] >> 1) + 17'(diff >> 8);
               end
               state_ff <= ST_MIX_MUL0;
            end
            ST_MIX_MUL0: state_ff <= ST_MIX_MUL1;
            ST_MIX_MUL1: begin
               ret_ff   <= ST_MIX_RND;
               state_ff <= ST_WAIT;
            end
            ST_MIX_RND: begin
               last_ff[ch_ff] <= sat32(acc_rnd);
               state_ff       <= ST_TRIM_MUL;
            end
            ST_TRIM_MUL: begin
               ret_ff   <= ST_TRIM_RND;
               state_ff <= ST_WAIT;
            end
            ST_TRIM_RND: begin
               t_ff     <= acc_rnd;
               state_ff <= ST_WET_MUL0;
            end
            ST_WET_MUL0: state_ff <= ST_WET_MUL1;
            ST_WET_MUL1: begin
               ret_ff   <= ST_OUT_RND;
               state_ff <= ST_WAIT;
            end
            ST_OUT_RND: begin
               if (out_half > 41'sd8388607) begin
                  out_ff[ch_ff] <= 24'sh7fffff;
               end else if (out_half < -41'sd8388608) begin
                  out_ff[ch_ff] <= 24'sh800000;
               end else begin
                  out_ff[ch_ff] <= 24'(out_half);
               end
               ch_ff    <= ~ch_ff;
               state_ff <= ch_ff ? ST_DONE : ST_IP_MUL0;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.out_left  <= out_ff[0];
                  rsp_data_ff.out_right <= out_ff[1];
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            ST_WAIT: state_ff <= ret_ff;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || ring_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
